>>> design/sorted_insert_priority_queue_unit_assert.svh
// assertion macros used by the priority queue checker
// expects clk_i and rst_ni in the scope of each use
`ifndef SORTED_INSERT_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/spq_pkg.sv
// shared types and codes of the sorted insert priority queue
// no dependencies
package spq_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned TAG_W = 16;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

endpackage

>>> design/spq_ifs.sv
// request and result channel interfaces of the priority queue
// depends on spq_pkg for field widths
interface spq_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [spq_pkg::KEY_W-1:0] item_key;
  logic [spq_pkg::TAG_W-1:0] item_tag;

  modport source (output valid, req_type, item_key, item_tag, input ready);
  modport sink   (input valid, req_type, item_key, item_tag, output ready);
endinterface

interface spq_res_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [spq_pkg::KEY_W-1:0] out_key;
  logic [spq_pkg::TAG_W-1:0] out_tag;
  logic                      is_empty;
  logic                      is_full;

  modport source (output valid, status, out_key, out_tag, is_empty, is_full, input ready);
  modport sink   (input valid, status, out_key, out_tag, is_empty, is_full, output ready);
endinterface

>>> design/spq_store.sv
// entry memory of the priority queue: one write and one read port
// read data is registered; depends on spq_pkg
module spq_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  spq_pkg::entry_t  wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output spq_pkg::entry_t  rdata_o
);

  spq_pkg::entry_t mem_q [DEPTH];
  spq_pkg::entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sorted_insert_priority_queue_unit.sv
// Sorted priority queue of DEPTH (key, tag) entries, largest key leaves first,
// equal keys in arrival order. Entries sit in a ring buffer in one memory
// with registered reads; removal takes the head entry and insertion walks
// from the tail toward the head, moving each smaller entry one slot back,
// one memory read and one write per cycle. One request at a time: a remove,
// an insert into an empty queue, or any dropped request goes from idle to done;
// any other insert scans, and visits put only if it moves every entry.
// A result waits in an output register, and the next request is taken while
// it waits. The memory needs no clearing after reset.
module sorted_insert_priority_queue_unit #(
  parameter int unsigned DEPTH = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_res_if.source res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    addr_inc = (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    addr_dec = (a == '0) ? LAST_ADDR : a - 1'b1;
  endfunction

  spq_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    occ_q, occ_d;
  logic [AW-1:0]    head_q, head_d;
  logic [AW-1:0]    tail_q, tail_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    wa_q, wa_d;
  logic [AW-1:0]    ra_q, ra_d;
  spq_pkg::entry_t  item_q, item_d;
  spq_pkg::status_e status_q, status_d;
  logic             rem_q, rem_d;

  logic                      out_valid_q, out_valid_d;
  spq_pkg::status_e          out_status_q, out_status_d;
  logic [spq_pkg::KEY_W-1:0] out_key_q, out_key_d;
  logic [spq_pkg::TAG_W-1:0] out_tag_q, out_tag_d;
  logic                      out_empty_q, out_empty_d;
  logic                      out_full_q, out_full_d;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  spq_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  spq_pkg::entry_t mem_rdata;
  logic            out_free;

  spq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_free    = !out_valid_q || res_o.ready;
  assign req_i.ready = (state_q == spq_pkg::S_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::S_IDLE;
      occ_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    wa_q         <= wa_d;
    ra_q         <= ra_d;
    item_q       <= item_d;
    status_q     <= status_d;
    rem_q        <= rem_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_tag_q    <= out_tag_d;
    out_empty_q  <= out_empty_d;
    out_full_q   <= out_full_d;
  end

  // request sequencer
  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    head_d       = head_q;
    tail_d       = tail_q;
    pos_d        = pos_q;
    wa_d         = wa_q;
    ra_d         = ra_q;
    item_d       = item_q;
    status_d     = status_q;
    rem_d        = rem_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_tag_d    = out_tag_q;
    out_empty_d  = out_empty_q;
    out_full_d   = out_full_q;
    mem_we       = 1'b0;
    mem_waddr    = wa_q;
    mem_wdata    = item_q;
    mem_re       = 1'b0;
    mem_raddr    = ra_q;

    // result taken downstream
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      spq_pkg::S_IDLE: begin
        if (req_i.valid) begin
          item_d.key = req_i.item_key;
          item_d.tag = req_i.item_tag;
          rem_d      = 1'b0;
          status_d   = spq_pkg::ST_OK;
          state_d    = spq_pkg::S_DONE;
          if (req_i.req_type == spq_pkg::REQ_INSERT) begin
            if (occ_q == FULL_CNT) begin
              status_d = spq_pkg::ST_OVERFLOW;
            end else begin
              occ_d  = occ_q + 1'b1;
              tail_d = addr_inc(tail_q);
              wa_d   = tail_q;
              pos_d  = occ_q;
              if (occ_q == '0) begin
                // empty queue: item goes straight to the tail
                mem_we        = 1'b1;
                mem_waddr     = tail_q;
                mem_wdata.key = req_i.item_key;
                mem_wdata.tag = req_i.item_tag;
              end else begin
                // fetch the last entry to start the walk
                mem_re    = 1'b1;
                mem_raddr = addr_dec(tail_q);
                ra_d      = addr_dec(tail_q);
                state_d   = spq_pkg::S_SCAN;
              end
            end
          end else begin
            if (occ_q == '0) begin
              status_d = spq_pkg::ST_UNDERFLOW;
            end else begin
              // read the head, the done state passes it to the result
              mem_re    = 1'b1;
              mem_raddr = head_q;
              head_d    = addr_inc(head_q);
              occ_d     = occ_q - 1'b1;
              rem_d     = 1'b1;
            end
          end
        end
      end

      spq_pkg::S_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = wa_q;
        if (item_q.key > mem_rdata.key) begin
          // move the smaller entry one slot back and keep walking
          mem_wdata = mem_rdata;
          wa_d      = ra_q;
          pos_d     = pos_q - 1'b1;
          if (pos_q == CW'(1)) begin
            state_d = spq_pkg::S_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = addr_dec(ra_q);
            ra_d      = addr_dec(ra_q);
          end
        end else begin
          state_d = spq_pkg::S_DONE;
        end
      end

      spq_pkg::S_PUT: begin
        // item becomes the new head
        mem_we    = 1'b1;
        mem_waddr = wa_q;
        state_d   = spq_pkg::S_DONE;
      end

      spq_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_key_d    = rem_q ? mem_rdata.key : '0;
          out_tag_d    = rem_q ? mem_rdata.tag : '0;
          out_empty_d  = (occ_q == '0);
          out_full_d   = (occ_q == FULL_CNT);
          state_d      = spq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

  // result channel
  assign res_o.valid    = out_valid_q;
  assign res_o.status   = out_status_q;
  assign res_o.out_key  = out_key_q;
  assign res_o.out_tag  = out_tag_q;
  assign res_o.is_empty = out_empty_q;
  assign res_o.is_full  = out_full_q;

endmodule

>>> design/spq_checker.sv
// port-level checks of the priority queue result channel, bound to the top
// depends on spq_pkg and the assertion macro header
`include "sorted_insert_priority_queue_unit_assert.svh"

module spq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [1:0]                status_i,
  input logic [spq_pkg::KEY_W-1:0] out_key_i,
  input logic [spq_pkg::TAG_W-1:0] out_tag_i,
  input logic                      is_empty_i,
  input logic                      is_full_i
);

  // a stalled result stays and holds its payload
  `SPQ_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(status_i) && $stable(out_key_i) && $stable(out_tag_i), "result changed while stalled")

  // a queue of at least two slots cannot be empty and full at once
  `SPQ_ASSERT_SAME(a_flags_excl, res_valid_i, !(is_empty_i && is_full_i), "empty and full together")

  // remove on empty reports an empty queue and zero payload
  `SPQ_ASSERT_SAME(a_underflow, res_valid_i && status_i == spq_pkg::ST_UNDERFLOW, is_empty_i && out_key_i == '0 && out_tag_i == '0, "bad underflow result")

  // dropped insert reports a full queue and zero payload
  `SPQ_ASSERT_SAME(a_overflow, res_valid_i && status_i == spq_pkg::ST_OVERFLOW, is_full_i && out_key_i == '0 && out_tag_i == '0, "bad overflow result")

endmodule

bind sorted_insert_priority_queue_unit spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .status_i    (res_o.status),
  .out_key_i   (res_o.out_key),
  .out_tag_i   (res_o.out_tag),
  .is_empty_i  (res_o.is_empty),
  .is_full_i   (res_o.is_full)
);
